// File: hdl/dmfa_pkg.sv
package dmfa_pkg;

    localparam int OP_W     = 2;
    localparam int SEQ_W    = 16;
    localparam int ADDR_W   = 64;
    localparam int STAMP_W  = 32;
    localparam int AGE_W    = 16;
    localparam int REPORT_W = 7;
    localparam int IPV4_W   = 32;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 4'd1;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_CLEAN_RD,
        S_CLEAN_CMP
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [ADDR_W-1:0]  addr_high;
        logic [ADDR_W-1:0]  addr_low;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// File: hdl/dmfa_in_if.sv
interface dmfa_in_if;
    logic                        valid;
    logic                        ready;
    logic [dmfa_pkg::OP_W-1:0]   operation;
    logic [dmfa_pkg::SEQ_W-1:0]  sequence_number;
    logic [dmfa_pkg::ADDR_W-1:0] address_high;
    logic [dmfa_pkg::ADDR_W-1:0] address_low;

    modport source (
        output valid, operation, sequence_number, address_high, address_low,
        input  ready
    );
    modport sink (
        input  valid, operation, sequence_number, address_high, address_low,
        output ready
    );
endinterface

// File: hdl/dmfa_out_if.sv
interface dmfa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_duplicate;
    logic                          overwrote_oldest;
    logic [dmfa_pkg::REPORT_W-1:0] removed_count;
    logic [dmfa_pkg::REPORT_W-1:0] entries_in_use;

    modport source (
        output valid, is_duplicate, overwrote_oldest, removed_count, entries_in_use,
        input  ready
    );
    modport sink (
        input  valid, is_duplicate, overwrote_oldest, removed_count, entries_in_use,
        output ready
    );
endinterface

// File: hdl/dmfa_cfg_if.sv
interface dmfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmfa_pkg::CFG_IDX_W-1:0]  index;
    logic [dmfa_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: hdl/duplicate_message_filter_aging_top.sv
// Duplicate message filter with aging. Each request carries an operation: a check looks
// the message up in a circular table of DEPTH entries and, if it is new, stores it
// stamped with the current second; a tick advances the seconds counter; a clean drops
// entries from the oldest on while their age exceeds max_age. Every request returns one
// response. All entries sit in a single memory with one read port, so lookups walk the
// table one entry per cycle. The block takes a new request only once the previous one
// has finished and its response slot is free.
module duplicate_message_filter_aging_top #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmfa_in_if.sink     i_req,
    dmfa_out_if.source  o_rsp,
    dmfa_cfg_if.sink    i_cfg
);
    import dmfa_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W:0]   WRAP_SUM   = (IDX_W + 1)'(DEPTH);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    t_state r_state, n_state;
    logic [STAMP_W-1:0] r_seconds, n_seconds;
    logic [IDX_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_mode, n_mode;
    logic [AGE_W-1:0]   r_max_age, n_max_age;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_issued, n_issued;
    logic               r_lat, n_lat;
    logic [CNT_W-1:0]   r_removed, n_removed;

    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]  r_lo, n_lo;

    logic                r_out_valid, n_out_valid;
    logic                r_out_dup, n_out_dup;
    logic                r_out_over, n_out_over;
    logic [REPORT_W-1:0] r_out_removed, n_out_removed;
    logic [REPORT_W-1:0] r_out_used, n_out_used;

    logic               in_fire;
    logic               out_fire;
    logic               match;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [IDX_W:0]     tail_sum;
    logic [STAMP_W-1:0] age;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        f_next = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_fire    = o_rsp.valid && o_rsp.ready;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.is_duplicate     = r_out_dup;
    assign o_rsp.overwrote_oldest = r_out_over;
    assign o_rsp.removed_count    = r_out_removed;
    assign o_rsp.entries_in_use   = r_out_used;

    assign match = r_lat && (r_rd_data.seq == r_seq) &&
                   (r_mode ? ((r_rd_data.addr_high == r_hi) && (r_rd_data.addr_low == r_lo))
                           : (r_rd_data.addr_low[IPV4_W-1:0] == r_lo[IPV4_W-1:0]));

    assign tail_sum = (IDX_W + 1)'(r_oldest) + (IDX_W + 1)'(r_count);
    assign age      = r_seconds - r_rd_data.stamp;

    always_comb begin
        n_state       = r_state;
        n_seconds     = r_seconds;
        n_oldest      = r_oldest;
        n_count       = r_count;
        n_mode        = r_mode;
        n_max_age     = r_max_age;
        n_ptr         = r_ptr;
        n_issued      = r_issued;
        n_lat         = 1'b0;
        n_removed     = r_removed;
        n_seq         = r_seq;
        n_hi          = r_hi;
        n_lo          = r_lo;
        n_out_valid   = r_out_valid && !out_fire;
        n_out_dup     = r_out_dup;
        n_out_over    = r_out_over;
        n_out_removed = r_out_removed;
        n_out_used    = r_out_used;
        rd_addr       = r_ptr;
        wr_en         = 1'b0;
        wr_addr       = r_oldest;
        wr_data.seq       = r_seq;
        wr_data.addr_high = r_hi;
        wr_data.addr_low  = r_lo;
        wr_data.stamp     = r_seconds;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ADDRESS_MODE: n_mode    = i_cfg.data[0];
                CFG_MAX_AGE:      n_max_age = i_cfg.data;
                default:          ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_seq = i_req.sequence_number;
                    n_hi  = i_req.address_high;
                    n_lo  = i_req.address_low;
                    unique case (i_req.operation)
                        OP_CHECK: begin
                            n_ptr    = r_oldest;
                            n_issued = '0;
                            n_state  = (r_count == '0) ? S_WRITE : S_SCAN;
                        end
                        OP_TICK: begin
                            n_seconds     = r_seconds + 1'b1;
                            n_out_valid   = 1'b1;
                            n_out_dup     = 1'b0;
                            n_out_over    = 1'b0;
                            n_out_removed = '0;
                            n_out_used    = REPORT_W'(r_count);
                        end
                        OP_CLEAN: begin
                            n_removed = '0;
                            n_state   = S_CLEAN_RD;
                        end
                        default: begin
                            n_out_valid   = 1'b1;
                            n_out_dup     = 1'b0;
                            n_out_over    = 1'b0;
                            n_out_removed = '0;
                            n_out_used    = REPORT_W'(r_count);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issued != r_count) begin
                    rd_addr  = r_ptr;
                    n_ptr    = f_next(r_ptr);
                    n_issued = r_issued + 1'b1;
                    n_lat    = 1'b1;
                end
                if (match) begin
                    n_lat         = 1'b0;
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_dup     = 1'b1;
                    n_out_over    = 1'b0;
                    n_out_removed = '0;
                    n_out_used    = REPORT_W'(r_count);
                end else if (r_issued == r_count) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                wr_en         = 1'b1;
                n_state       = S_IDLE;
                n_out_valid   = 1'b1;
                n_out_dup     = 1'b0;
                n_out_removed = '0;
                if (r_count == FULL_COUNT) begin
                    wr_addr    = r_oldest;
                    n_oldest   = f_next(r_oldest);
                    n_out_over = 1'b1;
                    n_out_used = REPORT_W'(r_count);
                end else begin
                    wr_addr    = (tail_sum >= WRAP_SUM) ? IDX_W'(tail_sum - WRAP_SUM)
                                                        : IDX_W'(tail_sum);
                    n_count    = r_count + 1'b1;
                    n_out_over = 1'b0;
                    n_out_used = REPORT_W'(r_count + 1'b1);
                end
            end
            S_CLEAN_RD: begin
                rd_addr = r_oldest;
                if (r_count == '0) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_dup     = 1'b0;
                    n_out_over    = 1'b0;
                    n_out_removed = REPORT_W'(r_removed);
                    n_out_used    = REPORT_W'(r_count);
                end else begin
                    n_state = S_CLEAN_CMP;
                end
            end
            S_CLEAN_CMP: begin
                if (age > STAMP_W'(r_max_age)) begin
                    n_oldest  = f_next(r_oldest);
                    n_count   = r_count - 1'b1;
                    n_removed = r_removed + 1'b1;
                    n_state   = S_CLEAN_RD;
                end else begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_dup     = 1'b0;
                    n_out_over    = 1'b0;
                    n_out_removed = REPORT_W'(r_removed);
                    n_out_used    = REPORT_W'(r_count);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seconds   <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_max_age   <= MAX_AGE_RESET;
            r_ptr       <= '0;
            r_issued    <= '0;
            r_lat       <= 1'b0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seconds   <= n_seconds;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_max_age   <= n_max_age;
            r_ptr       <= n_ptr;
            r_issued    <= n_issued;
            r_lat       <= n_lat;
            r_removed   <= n_removed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq         <= n_seq;
        r_hi          <= n_hi;
        r_lo          <= n_lo;
        r_out_dup     <= n_out_dup;
        r_out_over    <= n_out_over;
        r_out_removed <= n_out_removed;
        r_out_used    <= n_out_used;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // The table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("stored entry count exceeds table depth");

    // A tick request advances the seconds counter by exactly one.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_req.operation == OP_TICK)) |=> (r_seconds == $past(r_seconds) + 1'b1))
        else $error("tick did not advance the seconds counter");

    // Storing into a table that is not full grows it by one entry.
    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_count != FULL_COUNT)) |=>
            (r_count == $past(r_count) + 1'b1))
        else $error("store into a partly filled table did not add an entry");

    // A duplicate is never stored, so it never overwrites the oldest entry.
    a_dup_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_dup && r_out_over))
        else $error("response flags both duplicate and overwrite");

    // A finished response never appears while the block is still walking the table.
    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && !match && (r_issued != r_count)) |=> !$rose(r_out_valid))
        else $error("response issued in the middle of a table scan");

endmodule
